// ===== src/drd_pkg.sv =====
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants of the daylight ramp dimmer pipeline.
// ----------------------------------------------------------------------------
package drd_pkg;

  localparam int unsigned TOD_W    = 17;  // second of day, also register width
  localparam int unsigned NUM_W    = 24;  // 100 * elapsed plus ceiling bias
  localparam int unsigned QUO_W    = 7;   // brightness, 0..100
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TOD_W-1:0] SECONDS_PER_DAY = 17'd86400;
  localparam logic [QUO_W-1:0] FULL_SCALE      = 7'd100;

  // 86400 = 128 * 675; divide the upper 25 bits by 675 with a reciprocal
  localparam int unsigned       DAY_SHIFT   = 7;
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam int unsigned       RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_M    = 26'd50903316;  // floor(2^35 / 675)
  localparam int unsigned       PROD_W      = 32 - DAY_SHIFT + RECIP_W;
  localparam int unsigned       DAYQ_W      = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LENGTH = 3'd4;

  // Profile regions
  localparam logic [1:0] REGION_OFF  = 2'd0;
  localparam logic [1:0] REGION_RISE = 2'd1;
  localparam logic [1:0] REGION_FULL = 2'd2;
  localparam logic [1:0] REGION_FALL = 2'd3;

  typedef struct packed {
    logic             auto_mode;
    logic [TOD_W-1:0] light_start;
    logic [TOD_W-1:0] rise_length;
    logic [TOD_W-1:0] light_end;
    logic [TOD_W-1:0] fall_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       region;
    logic [NUM_W-1:0] rem;
    logic [TOD_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

endpackage

// ===== src/drd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// drd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module drd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drd_pkg::TOD_W-1:0]     cfg_wdata,
  output drd_pkg::cfg_t                 cfg
);
  import drd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode   <= 1'b1;
      cfg_r.light_start <= '0;
      cfg_r.rise_length <= '0;
      cfg_r.light_end   <= '0;
      cfg_r.fall_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AUTO_MODE:   cfg_r.auto_mode   <= cfg_wdata[0];
        CFG_LIGHT_START: cfg_r.light_start <= cfg_wdata;
        CFG_RISE_LENGTH: cfg_r.rise_length <= cfg_wdata;
        CFG_LIGHT_END:   cfg_r.light_end   <= cfg_wdata;
        CFG_FALL_LENGTH: cfg_r.fall_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/drd_tod.sv =====
// ----------------------------------------------------------------------------
// drd_tod
// Three-stage reduction of epoch seconds to a second of the day.
// ----------------------------------------------------------------------------
module drd_tod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [31:0]               in_epoch,
  output logic                      out_valid,
  output logic [drd_pkg::TOD_W-1:0] out_tod
);
  import drd_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic [31:0]       x1_r;
  logic [PROD_W-1:0] p1_r;
  logic [PROD_W-1:0] p1_nxt;
  logic [DAYQ_W-1:0] q2;
  logic [DAYQ_W+TOD_W-1:0] qd2;
  logic [TOD_W:0]    r2_r, r2_nxt;
  logic [TOD_W-1:0]  t3_r, t3_nxt;

  // Stage 1: estimate of floor(x / 86400), low by at most one
  assign p1_nxt = PROD_W'(in_epoch[31:DAY_SHIFT]) * PROD_W'(RECIP_M);

  // Stage 2: remainder against the estimate, below twice a day
  assign q2     = p1_r[RECIP_SHIFT +: DAYQ_W];
  assign qd2    = q2 * SECONDS_PER_DAY;
  assign r2_nxt = x1_r[TOD_W:0] - qd2[TOD_W:0];

  // Stage 3: final correction
  always_comb begin
    if (r2_r >= {1'b0, SECONDS_PER_DAY}) begin
      t3_nxt = TOD_W'(r2_r - {1'b0, SECONDS_PER_DAY});
    end else begin
      t3_nxt = r2_r[TOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_epoch;
      p1_r <= p1_nxt;
      r2_r <= r2_nxt;
      t3_r <= t3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_tod   = t3_r;

endmodule

// ===== src/drd_region.sv =====
// ----------------------------------------------------------------------------
// drd_region
// Picks the profile region for a second of the day and forms the ramp
// numerator and denominator for the divider.
// ----------------------------------------------------------------------------
module drd_region (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  drd_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [drd_pkg::TOD_W-1:0] in_tod,
  output logic                      out_valid,
  output drd_pkg::div_stage_t       out_req
);
  import drd_pkg::*;

  logic             v_r;
  div_stage_t       req_r, req_nxt;
  logic [TOD_W:0]   rise_end;
  logic [TOD_W:0]   fall_end;
  logic [TOD_W-1:0] elapsed;
  logic [NUM_W-1:0] scaled;

  assign rise_end = {1'b0, cfg.light_start} + {1'b0, cfg.rise_length};
  assign fall_end = {1'b0, cfg.light_end} + {1'b0, cfg.fall_length};

  always_comb begin
    req_nxt.region = REGION_OFF;
    req_nxt.den    = cfg.rise_length;
    req_nxt.quo    = '0;
    elapsed        = '0;
    if (in_tod < cfg.light_start) begin
      req_nxt.region = REGION_OFF;
    end else if ({1'b0, in_tod} < rise_end) begin
      req_nxt.region = REGION_RISE;
      elapsed        = in_tod - cfg.light_start;
    end else if (in_tod < cfg.light_end) begin
      req_nxt.region = REGION_FULL;
    end else if ({1'b0, in_tod} < fall_end) begin
      req_nxt.region = REGION_FALL;
      req_nxt.den    = cfg.fall_length;
      elapsed        = in_tod - cfg.light_end;
    end
    // 100 * elapsed as shifts and adds
    scaled = (NUM_W'(elapsed) << 6) + (NUM_W'(elapsed) << 5) + (NUM_W'(elapsed) << 2);
    // bias by length - 1 to turn the floor into a ceiling on the sunset ramp
    if (req_nxt.region == REGION_FALL) begin
      req_nxt.rem = scaled + NUM_W'(cfg.fall_length) - NUM_W'(1);
    end else begin
      req_nxt.rem = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= req_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_req   = req_r;

endmodule

// ===== src/drd_divider.sv =====
// ----------------------------------------------------------------------------
// drd_divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module drd_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  drd_pkg::div_stage_t       in_req,
  output logic                      out_valid,
  output drd_pkg::div_stage_t       out_res
);
  import drd_pkg::*;

  logic       vld_r [QUO_W];
  div_stage_t stg_r [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    div_stage_t       src;
    div_stage_t       stg_nxt;
    logic             src_v;
    logic [NUM_W-1:0] dsh;

    if (g == 0) begin : g_first
      assign src   = in_req;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = stg_r[g-1];
      assign src_v = vld_r[g-1];
    end

    // quotient never exceeds 100, so seven bits cover it
    always_comb begin
      dsh     = NUM_W'(src.den) << (QUO_W - 1 - g);
      stg_nxt = src;
      if (src.rem >= dsh) begin
        stg_nxt.rem                = src.rem - dsh;
        stg_nxt.quo[QUO_W - 1 - g] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[g] <= stg_nxt;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_res   = stg_r[QUO_W-1];

endmodule

// ===== src/daylight_ramp_dimmer.sv =====
// ----------------------------------------------------------------------------
// daylight_ramp_dimmer
// Maps epoch-second ticks to a brightness percentage from a daily profile.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output stalls, and returns its brightness:
// three stages reduce the tick to a second of the day (reciprocal multiply
// and one correction), one stage picks the region and forms the ramp
// numerator, seven stages run a restoring divide one quotient bit each, and
// the output register maps the quotient to 0, ramp, or 100. While automatic
// mode is off, words are accepted and dropped without a result. The whole
// pipeline holds while the output word waits; a stall drops nothing.
module daylight_ramp_dimmer (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [31:0] epoch_seconds
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  // out_tdata: [6:0] brightness, [7] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drd_pkg::TOD_W-1:0]     cfg_wdata
);
  import drd_pkg::*;

  cfg_t             cfg;
  logic             en;
  logic             tod_valid;
  logic [TOD_W-1:0] tod;
  logic             req_valid;
  div_stage_t       req;
  logic             res_valid;
  div_stage_t       res;
  logic             out_valid_r;
  logic [QUO_W-1:0] bright_r, bright_nxt;

  // advance everything whenever the output register is free or drains
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  drd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  drd_tod u_tod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid && cfg.auto_mode),
    .in_epoch  (in_tdata),
    .out_valid (tod_valid),
    .out_tod   (tod)
  );

  drd_region u_region (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (tod_valid),
    .in_tod    (tod),
    .out_valid (req_valid),
    .out_req   (req)
  );

  drd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (req_valid),
    .in_req    (req),
    .out_valid (res_valid),
    .out_res   (res)
  );

  always_comb begin
    case (res.region)
      REGION_RISE: bright_nxt = res.quo;
      REGION_FULL: bright_nxt = FULL_SCALE;
      REGION_FALL: bright_nxt = FULL_SCALE - res.quo;
      default:     bright_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bright_r <= bright_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, bright_r};

endmodule
